// ===== rtl/bitmap_block_allocator_assert.svh =====
// assertion macros for the bitmap block allocator checker
// each macro expects clk_i and rst_ni to be visible where it is used
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define BBA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and constants of the bitmap block allocator
// no dependencies

package bba_pkg;

  // default sizing
  localparam int unsigned NUM_BLOCKS_DEF = 4096;
  localparam int unsigned WORD_BITS_DEF  = 64;

  // fixed field widths
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned STAT_W = 2;

  // register port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // shift of the reciprocal used to split a block index into word and bit
  localparam int unsigned RECIP_SHIFT = 18;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MARK  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;

  // register select (address bit 2)
  localparam logic REG_FIRST_DATA  = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] FIRST_DATA_RESET  = 13'd1;
  localparam logic [CFG_W-1:0] BLOCK_COUNT_RESET = 13'd4096;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_FIX,
    ST_RMW,
    ST_RESP
  } bba_state_e;

endpackage

// ===== rtl/bba_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual-port ram, one write port, one registered read port
// depends on bba_pkg for default sizing

module bba_ram #(
  parameter int unsigned WIDTH = bba_pkg::WORD_BITS_DEF,
  parameter int unsigned DEPTH = bba_pkg::NUM_BLOCKS_DEF / bba_pkg::WORD_BITS_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  import bba_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/bitmap_block_allocator.sv =====
`timescale 1ns / 1ps
// top level of the first-fit bitmap block allocator
// depends on bba_pkg and bba_ram
//
// usage
// - request channel (in_valid_i / in_ready_o) carries req_type_i and block_index_i,
//   response channel (out_valid_o / out_ready_i) carries granted_block_o and status_o;
//   every request gives exactly one response transfer
// - one used bit per block, held in a ram of NUM_BLOCKS/WORD_BITS words
// - allocate scans from word 0, one word per cycle, grants the lowest free block in
//   [first data block, limit), or answers out of space once the scan passes the limit
// - free and mark split the index into word and bit (reciprocal multiply and one
//   correction), then read-modify-write the word
// - out-of-range free/mark and the unused request code skip to the response state
// - one request in flight at a time; the next is taken in the cycle after the response
//   is loaded into the output register, even while the receiver still stalls it
// - a stalled response holds in the output register; the engine waits in its
//   response state until the register frees up
// - after reset a clearing pass writes zero to every ram word, during which no request
//   is taken; register writes are taken any time, the block does not check for idle
// - registers: first data block at 0x0, block count at 0x4, user writes only while idle

module bitmap_block_allocator #(
  parameter int unsigned NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bba_pkg::REQ_W-1:0]   req_type_i,
  input  logic [bba_pkg::IDX_W-1:0]   block_index_i,
  // response channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bba_pkg::IDX_W-1:0]   granted_block_o,
  output logic [bba_pkg::STAT_W-1:0]  status_o,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bba_pkg::APB_AW-1:0]  paddr,
  input  logic [bba_pkg::APB_DW-1:0]  pwdata,
  output logic [bba_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import bba_pkg::*;

  // sizing
  localparam int unsigned DEPTH = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned BITW  = $clog2(WORD_BITS);
  localparam int unsigned LW    = $clog2(NUM_BLOCKS + 1);
  // compare width: holds the limit plus one word of overshoot
  localparam int unsigned CW    = ((LW > CFG_W) ? LW : CFG_W) + 1;
  localparam int unsigned PW    = IDX_W + RECIP_SHIFT;
  localparam int unsigned RECIP = (1 << RECIP_SHIFT) / WORD_BITS;

  bba_state_e state_q, state_d;

  // configuration
  logic [CFG_W-1:0] first_q, first_d;
  logic [CFG_W-1:0] total_q, total_d;
  logic             cfg_wr;

  // request
  logic [REQ_W-1:0] req_q, req_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] quot_q, quot_d;
  logic [AW-1:0]    waddr_q, waddr_d;
  logic [BITW-1:0]  bit_q, bit_d;

  // scan pipeline: read address side and returning data side
  logic [AW-1:0]    raddr_q, raddr_d;
  logic [CW-1:0]    rbase_q, rbase_d;
  logic [AW-1:0]    dword_q, dword_d;
  logic [CW-1:0]    dbase_q, dbase_d;
  logic             dvalid_q, dvalid_d;

  // clearing pass
  logic [AW-1:0]    clr_q, clr_d;
  logic             clr_last;

  // pending result and output register
  logic [IDX_W-1:0]  res_grant_q, res_grant_d;
  logic [STAT_W-1:0] res_stat_q, res_stat_d;
  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  out_grant_q, out_grant_d;
  logic [STAT_W-1:0] out_stat_q, out_stat_d;

  // ram
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // datapath helpers
  logic [CW-1:0]        lim;
  logic [CW-1:0]        lo_off, hi_off;
  logic [WORD_BITS-1:0] avail;
  logic [BITW-1:0]      pos;
  logic                 found;
  logic                 issue;
  logic                 in_fire;
  logic                 idx_bad;
  logic                 slot_free;
  logic [PW-1:0]        prod;
  logic [IDX_W-1:0]     rem0;
  logic                 rem_fix;
  logic [IDX_W-1:0]     quot;
  logic [IDX_W-1:0]     rem;

  bba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(DEPTH)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // register port, always ready, word addressed by bit 2
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_BLOCK_COUNT) ? APB_DW'(total_q) : APB_DW'(first_q);

  always_comb begin
    first_d = first_q;
    total_d = total_q;
    if (cfg_wr) begin
      if (paddr[2] == REG_FIRST_DATA) begin
        first_d = pwdata[CFG_W-1:0];
      end else begin
        total_d = pwdata[CFG_W-1:0];
      end
    end
  end

  // block limit: block count clamped to the bitmap size
  assign lim = (CW'(total_q) < CW'(NUM_BLOCKS)) ? CW'(total_q) : CW'(NUM_BLOCKS);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign idx_bad    = (CW'(block_index_i) >= lim);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign clr_last   = (clr_q == AW'(DEPTH - 1));

  // scan: free bits of the returning word inside [first_data_block, limit)
  assign lo_off = (CW'(first_q) > dbase_q) ? CW'(first_q) - dbase_q : '0;
  assign hi_off = (lim > dbase_q) ? lim - dbase_q : '0;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      avail[j] = !ram_rdata[j] && (CW'(j) >= lo_off) && (CW'(j) < hi_off);
    end
  end

  // lowest free bit
  always_comb begin
    pos = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (avail[j]) begin
        pos = BITW'(j);
      end
    end
  end

  assign found = dvalid_q && (|avail);
  // keep fetching while the next word still starts below the limit
  assign issue = (rbase_q < lim);

  // index split: quotient estimate by reciprocal, then one correction step
  assign prod    = PW'(idx_q) * PW'(RECIP);
  assign rem0    = idx_q - IDX_W'(quot_q * IDX_W'(WORD_BITS));
  assign rem_fix = (rem0 >= IDX_W'(WORD_BITS));
  assign quot    = rem_fix ? quot_q + IDX_W'(1) : quot_q;
  assign rem     = rem_fix ? rem0 - IDX_W'(WORD_BITS) : rem0;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          priority if (req_type_i == REQ_ALLOC) begin
            state_d = ST_SCAN;
          end else if ((req_type_i == REQ_FREE || req_type_i == REQ_MARK) && !idx_bad) begin
            state_d = ST_DIV;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (found || (!dvalid_q && !issue)) begin
          state_d = ST_RESP;
        end
      end
      ST_DIV:  state_d = ST_FIX;
      ST_FIX:  state_d = ST_RMW;
      ST_RMW:  state_d = ST_RESP;
      ST_RESP: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    req_d       = req_q;
    idx_d       = idx_q;
    quot_d      = quot_q;
    waddr_d     = waddr_q;
    bit_d       = bit_q;
    raddr_d     = raddr_q;
    rbase_d     = rbase_q;
    dword_d     = dword_q;
    dbase_d     = dbase_q;
    dvalid_d    = dvalid_q;
    clr_d       = clr_q;
    res_grant_d = res_grant_q;
    res_stat_d  = res_stat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_grant_d = out_grant_q;
    out_stat_d  = out_stat_q;
    ram_we      = 1'b0;
    ram_waddr   = waddr_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = raddr_q;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          req_d       = req_type_i;
          idx_d       = block_index_i;
          raddr_d     = '0;
          rbase_d     = '0;
          dvalid_d    = 1'b0;
          res_grant_d = '0;
          res_stat_d  = STAT_OK;
          if ((req_type_i == REQ_FREE || req_type_i == REQ_MARK) && idx_bad) begin
            res_stat_d = STAT_RANGE;
          end
        end
      end
      ST_SCAN: begin
        ram_raddr = raddr_q;
        dvalid_d  = issue;
        dword_d   = raddr_q;
        dbase_d   = rbase_q;
        raddr_d   = raddr_q + AW'(1);
        rbase_d   = rbase_q + CW'(WORD_BITS);
        if (found) begin
          ram_we      = 1'b1;
          ram_waddr   = dword_q;
          ram_wdata   = ram_rdata | (WORD_BITS'(1) << pos);
          res_grant_d = IDX_W'(dbase_q + CW'(pos));
          res_stat_d  = STAT_OK;
        end else if (!dvalid_q && !issue) begin
          res_grant_d = '0;
          res_stat_d  = STAT_NOSPACE;
        end
      end
      ST_DIV: begin
        quot_d = prod[RECIP_SHIFT +: IDX_W];
      end
      ST_FIX: begin
        ram_raddr = AW'(quot);
        waddr_d   = AW'(quot);
        bit_d     = BITW'(rem);
      end
      ST_RMW: begin
        ram_we    = 1'b1;
        ram_waddr = waddr_q;
        if (req_q == REQ_MARK) begin
          ram_wdata = ram_rdata | (WORD_BITS'(1) << bit_q);
        end else begin
          ram_wdata = ram_rdata & ~(WORD_BITS'(1) << bit_q);
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_grant_d = res_grant_q;
          out_stat_d  = res_stat_q;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      first_q     <= FIRST_DATA_RESET;
      total_q     <= BLOCK_COUNT_RESET;
      clr_q       <= '0;
      dvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      total_q     <= total_d;
      clr_q       <= clr_d;
      dvalid_q    <= dvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    idx_q       <= idx_d;
    quot_q      <= quot_d;
    waddr_q     <= waddr_d;
    bit_q       <= bit_d;
    raddr_q     <= raddr_d;
    rbase_q     <= rbase_d;
    dword_q     <= dword_d;
    dbase_q     <= dbase_d;
    res_grant_q <= res_grant_d;
    res_stat_q  <= res_stat_d;
    out_grant_q <= out_grant_d;
    out_stat_q  <= out_stat_d;
  end

  assign out_valid_o     = out_valid_q;
  assign granted_block_o = out_grant_q;
  assign status_o        = out_stat_q;

endmodule

// ===== rtl/bba_checker.sv =====
`timescale 1ns / 1ps
// port-level checker for the bitmap block allocator, bound to the top level
// depends on bba_pkg and bitmap_block_allocator_assert.svh

`include "bitmap_block_allocator_assert.svh"

module bba_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [bba_pkg::REQ_W-1:0]   req_type_i,
  input logic [bba_pkg::IDX_W-1:0]   block_index_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [bba_pkg::IDX_W-1:0]   granted_block_o,
  input logic [bba_pkg::STAT_W-1:0]  status_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [bba_pkg::APB_AW-1:0]  paddr,
  input logic [bba_pkg::APB_DW-1:0]  pwdata,
  input logic [bba_pkg::APB_DW-1:0]  prdata,
  input logic                        pready
);
  import bba_pkg::*;

  // a stalled response holds its payload
  `BBA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(granted_block_o) && $stable(status_o), "stalled response changed")

  // only defined status codes leave the block
  `BBA_ASSERT_ALWAYS(a_status_code, !out_valid_o || status_o == STAT_OK || status_o == STAT_NOSPACE || status_o == STAT_RANGE, "undefined status code")

  // failures never carry a block number
  `BBA_ASSERT_ALWAYS(a_fail_zero, !(out_valid_o && status_o != STAT_OK) || granted_block_o == '0, "failed request with nonzero grant")

  // one request at a time: a transfer in closes the request channel
  `BBA_ASSERT_NEXT(a_one_inflight, in_valid_i && in_ready_o, !in_ready_o, "request taken while busy")

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
